// ----- src/sdh_pkg.sv -----
// Shared types, codes and constants for the standstill detector.
package sdh_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_TIME      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_UP_ALIGNMENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_LIMITS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_LIMITS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SLIP_LIMITS       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSPENSION_LIMITS = 3'd5;

    // Progress is an 8-bit quotient, with one extra code for complete.
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [8:0] PROGRESS_FULL = 9'd256;

    typedef enum logic [1:0] {
        MODE_MOVING    = 2'd0,
        MODE_CANDIDATE = 2'd1,
        MODE_STOPPED   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        CAUSE_NONE       = 4'd0,
        CAUSE_DRIVE      = 4'd1,
        CAUSE_INVALID    = 4'd2,
        CAUSE_CONTACT    = 4'd3,
        CAUSE_POSE       = 4'd4,
        CAUSE_LINEAR     = 4'd5,
        CAUSE_ANGULAR    = 4'd6,
        CAUSE_SLIP       = 4'd7,
        CAUSE_SUSPENSION = 4'd8,
        CAUSE_ENTERED    = 4'd9,
        CAUSE_CONFIRMED  = 4'd10
    } cause_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EVAL = 2'd1,
        ST_DIV  = 2'd2,
        ST_LOAD = 2'd3
    } ctrl_state_t;

    typedef struct packed {
        logic               drive_requested;
        logic               values_valid;
        logic               has_contact;
        logic signed [15:0] up_alignment;
        logic [15:0]        linear_speed;
        logic [15:0]        angular_speed;
        logic [15:0]        slip_left;
        logic [15:0]        slip_right;
        logic [15:0]        suspension_left;
        logic [15:0]        suspension_right;
        logic [15:0]        elapsed_time;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mobility_mode;
        logic [3:0]  transition_cause;
        logic [31:0] time_in_mode;
        logic [8:0]  stop_progress;
    } out_item_t;

    typedef struct packed {
        logic [23:0]        confirm_time;
        logic signed [15:0] min_up_alignment;
        logic [31:0]        linear_limits;
        logic [31:0]        angular_limits;
        logic [31:0]        slip_limits;
        logic [31:0]        suspension_limits;
    } cfg_t;

    // Controller to datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic load;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/standstill_detector_hysteresis.sv -----
// Top level of the standstill detector with hysteresis.
// Each input item is one observation tick and yields exactly one result item
// carrying the mode, the last transition cause, the time in mode and the
// stop progress. The block works on one item at a time: an item is captured,
// then the thresholds are evaluated and the mode machine is stepped, then
// the bit-serial restoring division forms the progress quotient, then the
// output register is loaded, which waits while an earlier result not yet
// taken still occupies it; only after the load can the next item be accepted.
// The output register lets the next item enter while a finished result still
// waits. There is no clearing pass after reset. Configuration writes are
// always ready and must only be issued while no item is in flight; unknown
// indexes are ignored.
module standstill_detector_hysteresis
    import sdh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    sdh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    sdh_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- src/sdh_cfg_regs.sv -----
// Configuration register file of the standstill detector.
module sdh_cfg_regs
    import sdh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Writes are always taken; indexes beyond the list are dropped.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CONFIRM_TIME:      cfg_reg.confirm_time      <= cfg_data[23:0];
                CFG_MIN_UP_ALIGNMENT:  cfg_reg.min_up_alignment  <= $signed(cfg_data[15:0]);
                CFG_LINEAR_LIMITS:     cfg_reg.linear_limits     <= cfg_data;
                CFG_ANGULAR_LIMITS:    cfg_reg.angular_limits    <= cfg_data;
                CFG_SLIP_LIMITS:       cfg_reg.slip_limits       <= cfg_data;
                CFG_SUSPENSION_LIMITS: cfg_reg.suspension_limits <= cfg_data;
                default:               ;
            endcase
        end
    end

endmodule

// ----- src/sdh_ctrl.sv -----
// Sequencing state machine: accept, evaluate, divide, then hand to the output register.
module sdh_ctrl
    import sdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t          state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 div_last;

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EVAL: cmd.eval     = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_LOAD: cmd.load     = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // A new item is only taken with the datapath idle.
    a_capture_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> state_reg == ST_EVAL)
        else $error("capture did not lead to evaluation");
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |=> (state_reg == ST_DIV) && (cnt_reg == '0))
        else $error("division did not start from step zero");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_IDLE)
        else $error("controller stayed after loading a result");

endmodule

// ----- src/sdh_datapath.sv -----
// Mode state, saturating timer, threshold checks, progress divider and output register.
module sdh_datapath
    import sdh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  in_item_t   in_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    mode_t     mode_reg, mode_next;
    cause_t    cause_reg, cause_next;
    logic [31:0] timer_reg, timer_next;
    in_item_t  item_reg;
    logic [24:0] rem_reg;
    logic [7:0]  quot_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic [32:0] timer_sum;
    logic [31:0] timer_sat;
    cause_t      fail;
    logic [24:0] rem_shift;
    logic [24:0] divisor;
    logic        div_bit;
    logic [8:0]  progress;

    // Priority-ordered failure check against enter or exit thresholds.
    function automatic cause_t check_failure(input in_item_t it, input cfg_t c,
                                             input logic exiting);
        logic [15:0] slip;
        logic [15:0] susp;
        logic [15:0] lim_lin;
        logic [15:0] lim_ang;
        logic [15:0] lim_slip;
        logic [15:0] lim_susp;
        slip     = (it.slip_left > it.slip_right) ? it.slip_left : it.slip_right;
        susp     = (it.suspension_left > it.suspension_right) ?
                   it.suspension_left : it.suspension_right;
        lim_lin  = exiting ? c.linear_limits[31:16]     : c.linear_limits[15:0];
        lim_ang  = exiting ? c.angular_limits[31:16]    : c.angular_limits[15:0];
        lim_slip = exiting ? c.slip_limits[31:16]       : c.slip_limits[15:0];
        lim_susp = exiting ? c.suspension_limits[31:16] : c.suspension_limits[15:0];
        if (it.drive_requested)
            return CAUSE_DRIVE;
        if (!it.values_valid)
            return CAUSE_INVALID;
        if (!it.has_contact)
            return CAUSE_CONTACT;
        if (it.up_alignment < c.min_up_alignment)
            return CAUSE_POSE;
        if (it.linear_speed >= lim_lin)
            return CAUSE_LINEAR;
        if (it.angular_speed >= lim_ang)
            return CAUSE_ANGULAR;
        if (slip >= lim_slip)
            return CAUSE_SLIP;
        if (susp >= lim_susp)
            return CAUSE_SUSPENSION;
        return CAUSE_NONE;
    endfunction

    // Saturating time accumulation.
    assign timer_sum = {1'b0, timer_reg} + {17'd0, item_reg.elapsed_time};
    assign timer_sat = timer_sum[32] ? '1 : timer_sum[31:0];
    assign fail      = check_failure(item_reg, cfg, mode_reg == MODE_STOPPED);

    // Mode transition for one tick.
    always_comb
    begin
        mode_next  = mode_reg;
        cause_next = cause_reg;
        timer_next = timer_sat;
        case (mode_reg)
            MODE_CANDIDATE:
            begin
                if (fail != CAUSE_NONE)
                begin
                    mode_next  = MODE_MOVING;
                    cause_next = fail;
                    timer_next = '0;
                end
                else if (timer_sat >= {8'd0, cfg.confirm_time})
                begin
                    mode_next  = MODE_STOPPED;
                    cause_next = CAUSE_CONFIRMED;
                    timer_next = '0;
                end
            end
            MODE_STOPPED:
            begin
                if (fail != CAUSE_NONE)
                begin
                    mode_next  = MODE_MOVING;
                    cause_next = fail;
                    timer_next = '0;
                end
            end
            default:
            begin
                mode_next = MODE_MOVING;
                if (fail == CAUSE_NONE)
                begin
                    mode_next  = MODE_CANDIDATE;
                    cause_next = CAUSE_ENTERED;
                    timer_next = '0;
                end
            end
        endcase
    end

    // One restoring division step. A candidate's timer stays below the
    // confirm time, so the remainder fits and the quotient has 8 bits.
    assign divisor   = {1'b0, cfg.confirm_time};
    assign rem_shift = {rem_reg[23:0], 1'b0};
    assign div_bit   = (rem_shift >= divisor);

    // Progress is only shown while a candidate.
    always_comb
    begin
        progress = '0;
        if (mode_reg == MODE_CANDIDATE)
        begin
            progress = (cfg.confirm_time == '0) ? PROGRESS_FULL : {1'b0, quot_reg};
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

    // Detector state and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_MOVING;
            cause_reg     <= CAUSE_NONE;
            timer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                mode_reg  <= mode_next;
                cause_reg <= cause_next;
                timer_reg <= timer_next;
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, divider and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        if (cmd.eval)
        begin
            rem_reg  <= {1'b0, timer_next[23:0]};
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= div_bit ? (rem_shift - divisor) : rem_shift;
            quot_reg <= {quot_reg[6:0], div_bit};
        end
        if (cmd.load)
        begin
            out_reg.mobility_mode    <= mode_reg;
            out_reg.transition_cause <= cause_reg;
            out_reg.time_in_mode     <= timer_reg;
            out_reg.stop_progress    <= progress;
        end
    end

    a_progress_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.stop_progress != '0) |->
            out_reg.mobility_mode == MODE_CANDIDATE)
        else $error("progress shown outside the candidate mode");
    a_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && (mode_next != mode_reg) |=> timer_reg == '0)
        else $error("timer not cleared on a mode change");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step && (mode_reg == MODE_CANDIDATE) && (cfg.confirm_time != '0) |->
            rem_reg < divisor)
        else $error("divider remainder out of range");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over one not yet taken");

endmodule
